// ===== hdl/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DW           = 16;
  localparam int FB           = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_BITS     = DW + 1;
  localparam int REM_W        = 2 * DW + DIV_BITS;
  localparam int SQRT_STEPS   = DW;
  localparam int ZW           = 36;
  localparam int CW           = 64;
  localparam int LIFT         = 61 - DW;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [CW-1:0] Q30_GAIN    = 64'sd652032874;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAGSQ, OP_MAG, OP_ARG, OP_POLAR
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cmd_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic [1:0]           status;
  } res_t;

  typedef struct packed {
    logic                 vld;
    op_t                  op;
    logic signed [DW-1:0] rr;
    logic signed [DW-1:0] ri;
    logic                 flg;
    logic                 dz;
    logic signed [DW-1:0] ar;
    logic [2*DW-1:0]      den;
    logic                 nneg_re;
    logic                 nneg_im;
    logic                 big_re;
    logic                 big_im;
    logic [REM_W-1:0]     rem_re;
    logic [REM_W-1:0]     rem_im;
    logic [DIV_BITS-1:0]  q_re;
    logic [DIV_BITS-1:0]  q_im;
    logic [2*DW-1:0]      sq_n;
    logic [2*DW-1:0]      sq_r;
    logic                 vec;
    logic                 zero;
    logic                 flip;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
  } iter_t;

  function automatic logic signed [ZW-1:0] cau_atan(input int unsigned i);
    case (i)
      0:  return 36'sh03243F6A8;
      1:  return 36'sh01DAC6705;
      2:  return 36'sh00FADBAFC;
      3:  return 36'sh007F56EA6;
      4:  return 36'sh003FEAB76;
      5:  return 36'sh001FFD55B;
      6:  return 36'sh000FFFAAA;
      7:  return 36'sh0007FFF55;
      8:  return 36'sh0003FFFEA;
      9:  return 36'sh0001FFFFD;
      10: return 36'sh0000FFFFF;
      11: return 36'sh00007FFFF;
      12: return 36'sh00003FFFF;
      13: return 36'sh00001FFFF;
      14: return 36'sh00000FFFF;
      15: return 36'sh000007FFF;
      16: return 36'sh000003FFF;
      17: return 36'sh000001FFF;
      18: return 36'sh000000FFF;
      19: return 36'sh0000007FF;
      20: return 36'sh0000003FF;
      21: return 36'sh0000001FF;
      22: return 36'sh0000000FF;
      23: return 36'sh00000007F;
      24: return 36'sh00000003F;
      25: return 36'sh00000001F;
      26: return 36'sh00000000F;
      27: return 36'sh000000008;
      28: return 36'sh000000004;
      29: return 36'sh000000002;
      30: return 36'sh000000001;
      default: return 36'sh000000000;
    endcase
  endfunction

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// channel  | ports             | transaction
// ---------+-------------------+-------------------------------------------
// command  | start, busy, cmd  | taken at a rising edge with start high
// result   | done, res         | on res for one cycle while done is high
//
// A transaction is taken in every cycle; busy is always low.
// Results leave in order; the pipeline depth is set by the 17-step divider and
// the CORDIC rotator, one step per stage.
// Reset clears the valid bits of every stage; payload is not reset.
// The receiver cannot stall, so the pipeline advances in every cycle.
module complex_arithmetic_unit #(
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::cmd_t cmd,
  output logic          done,
  output cau_pkg::res_t res
);
  import cau_pkg::*;

  localparam int CS    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int ITERS = (CS > DIV_BITS) ? CS : DIV_BITS;

  function automatic logic [DW:0] sat16(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] nm;
    lim = 64'd1 << (DW - 1);
    nm  = 64'd0 - mag;
    if (neg) begin
      if (mag > lim) return {1'b1, lim[DW-1:0]};
      return {1'b0, nm[DW-1:0]};
    end
    nm = lim - 64'd1;
    if (mag > nm) return {1'b1, nm[DW-1:0]};
    return {1'b0, mag[DW-1:0]};
  endfunction

  function automatic logic [DW:0] sat_int(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'd0 - 64'(v) : 64'(v);
    return sat16(v[63], m);
  endfunction

  function automatic logic [DW:0] rnd_sat(input logic signed [63:0] v,
                                          input int unsigned sh);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? 64'd0 - 64'(v) : 64'(v);
    m   = (m + (64'd1 << (sh - 1))) >> sh;
    return sat16(neg && (m != 64'd0), m);
  endfunction

  // input register
  logic s0_vld;
  cmd_t s0_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start;
    end
    s0_c <= cmd;
  end

  assign busy = 1'b0;

  // stage 1: products, add/sub, angle reduction, vectoring fold
  logic                   s1_vld;
  op_t                    s1_op;
  logic signed [DW-1:0]   s1_ar, s1_rr, s1_ri;
  logic                   s1_flg;
  logic signed [2*DW-1:0] p_rr, p_ii, p_ri, p_ir, p_b1, p_b2, p_a1, p_a2;
  logic signed [ZW-1:0]   s1_th, s1_z;
  logic signed [CW-1:0]   s1_x, s1_y;
  logic                   s1_zero;

  op_t                    c_op;
  logic signed [DW:0]     c_sre, c_sim;
  logic [DW:0]            c_tre, c_tim;
  logic signed [ZW-1:0]   c_th0, c_th1;
  logic signed [CW-1:0]   c_x0, c_y0;

  always_comb begin
    c_op  = op_t'(s0_c.opcode);
    c_sre = (c_op == OP_SUB) ? (DW+1)'(s0_c.a_re) - (DW+1)'(s0_c.b_re)
                             : (DW+1)'(s0_c.a_re) + (DW+1)'(s0_c.b_re);
    c_sim = (c_op == OP_SUB) ? (DW+1)'(s0_c.a_im) - (DW+1)'(s0_c.b_im)
                             : (DW+1)'(s0_c.a_im) + (DW+1)'(s0_c.b_im);
    c_tre = sat_int(64'(c_sre));
    c_tim = sat_int(64'(c_sim));
    c_th0 = ZW'(s0_c.a_im) <<< (30 - FB);
    if (c_th0 >= Q30_TWO_PI) begin
      c_th1 = c_th0 - Q30_TWO_PI;
    end else if (c_th0 <= -Q30_TWO_PI) begin
      c_th1 = c_th0 + Q30_TWO_PI;
    end else begin
      c_th1 = c_th0;
    end
    c_x0 = CW'(s0_c.a_re) <<< LIFT;
    c_y0 = CW'(s0_c.a_im) <<< LIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s0_vld;
    end
    s1_op   <= c_op;
    s1_ar   <= s0_c.a_re;
    s1_rr   <= c_tre[DW-1:0];
    s1_ri   <= c_tim[DW-1:0];
    s1_flg  <= c_tre[DW] | c_tim[DW];
    p_rr    <= s0_c.a_re * s0_c.b_re;
    p_ii    <= s0_c.a_im * s0_c.b_im;
    p_ri    <= s0_c.a_re * s0_c.b_im;
    p_ir    <= s0_c.a_im * s0_c.b_re;
    p_b1    <= s0_c.b_re * s0_c.b_re;
    p_b2    <= s0_c.b_im * s0_c.b_im;
    p_a1    <= s0_c.a_re * s0_c.a_re;
    p_a2    <= s0_c.a_im * s0_c.a_im;
    s1_th   <= c_th1;
    s1_zero <= (s0_c.a_re == '0) && (s0_c.a_im == '0);
    if (s0_c.a_re[DW-1]) begin
      s1_x <= -c_x0;
      s1_y <= -c_y0;
      s1_z <= s0_c.a_im[DW-1] ? -Q30_PI : Q30_PI;
    end else begin
      s1_x <= c_x0;
      s1_y <= c_y0;
      s1_z <= '0;
    end
  end

  // stage 2: sums of products, wrap angle into [-pi, pi]
  logic                 s2_vld;
  op_t                  s2_op;
  logic signed [DW-1:0] s2_ar, s2_rr, s2_ri;
  logic                 s2_flg;
  logic signed [2*DW:0] s2_nr, s2_ni, s2_dnr, s2_dni;
  logic [2*DW-1:0]      s2_den, s2_msq;
  logic signed [ZW-1:0] s2_th, s2_z;
  logic signed [CW-1:0] s2_x, s2_y;
  logic                 s2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_op   <= s1_op;
    s2_ar   <= s1_ar;
    s2_rr   <= s1_rr;
    s2_ri   <= s1_ri;
    s2_flg  <= s1_flg;
    s2_nr   <= (2*DW+1)'(p_rr) - (2*DW+1)'(p_ii);
    s2_ni   <= (2*DW+1)'(p_ri) + (2*DW+1)'(p_ir);
    s2_dnr  <= (2*DW+1)'(p_rr) + (2*DW+1)'(p_ii);
    s2_dni  <= (2*DW+1)'(p_ir) - (2*DW+1)'(p_ri);
    s2_den  <= $unsigned(p_b1) + $unsigned(p_b2);
    s2_msq  <= $unsigned(p_a1) + $unsigned(p_a2);
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_z    <= s1_z;
    s2_zero <= s1_zero;
    if (s1_th > Q30_PI) begin
      s2_th <= s1_th - Q30_TWO_PI;
    end else if (s1_th < -Q30_PI) begin
      s2_th <= s1_th + Q30_TWO_PI;
    end else begin
      s2_th <= s1_th;
    end
  end

  // stage 3: rounding of products, divider and root set-up, CORDIC set-up
  iter_t              s3, s3_next;
  logic [2*DW:0]      an_re, an_im;
  logic [DW:0]        t_mr, t_mi, t_sq;

  always_comb begin
    an_re   = s2_dnr[2*DW] ? -s2_dnr : s2_dnr;
    an_im   = s2_dni[2*DW] ? -s2_dni : s2_dni;
    t_mr    = rnd_sat(64'(s2_nr), FB);
    t_mi    = rnd_sat(64'(s2_ni), FB);
    t_sq    = rnd_sat(64'(s2_msq), FB);
    s3_next = '0;
    s3_next.vld     = s2_vld && !rst;
    s3_next.op      = s2_op;
    s3_next.ar      = s2_ar;
    s3_next.den     = s2_den;
    s3_next.dz      = (s2_den == '0);
    s3_next.nneg_re = s2_dnr[2*DW];
    s3_next.nneg_im = s2_dni[2*DW];
    s3_next.rem_re  = REM_W'({an_re[2*DW-1:0], {FB{1'b0}}});
    s3_next.rem_im  = REM_W'({an_im[2*DW-1:0], {FB{1'b0}}});
    s3_next.big_re  = s3_next.rem_re >= {s2_den, {DIV_BITS{1'b0}}};
    s3_next.big_im  = s3_next.rem_im >= {s2_den, {DIV_BITS{1'b0}}};
    s3_next.sq_n    = s2_msq;
    s3_next.zero    = s2_zero;
    unique case (s2_op)
      OP_ADD, OP_SUB: begin
        s3_next.rr  = s2_rr;
        s3_next.ri  = s2_ri;
        s3_next.flg = s2_flg;
      end
      OP_MUL: begin
        s3_next.rr  = t_mr[DW-1:0];
        s3_next.ri  = t_mi[DW-1:0];
        s3_next.flg = t_mr[DW] | t_mi[DW];
      end
      OP_MAGSQ: begin
        s3_next.rr  = t_sq[DW-1:0];
        s3_next.flg = t_sq[DW];
      end
      OP_ARG: begin
        s3_next.vec = 1'b1;
        s3_next.cx  = s2_x;
        s3_next.cy  = s2_y;
        s3_next.cz  = s2_z;
      end
      OP_POLAR: begin
        s3_next.cx = Q30_GAIN;
        if (s2_th > Q30_HALF_PI) begin
          s3_next.cz   = s2_th - Q30_PI;
          s3_next.flip = 1'b1;
        end else if (s2_th < -Q30_HALF_PI) begin
          s3_next.cz   = s2_th + Q30_PI;
          s3_next.flip = 1'b1;
        end else begin
          s3_next.cz = s2_th;
        end
      end
      OP_DIV, OP_MAG: begin
        s3_next.flg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s3 <= s3_next;
  end

  // shared iteration stages: divider, root, CORDIC
  iter_t stg [0:ITERS];

  assign stg[0] = s3;

  for (genvar k = 0; k < ITERS; k++) begin : g_it
    cau_iter #(
      .IDX (k),
      .CS  (CS)
    ) u_iter (
      .clk (clk),
      .rst (rst),
      .d   (stg[k]),
      .q   (stg[k+1])
    );
  end

  // finish stage 1: quotients, root, angle, polar products
  iter_t                   it;
  logic                    f1_vld;
  op_t                     f1_op;
  logic signed [DW-1:0]    f1_rr, f1_ri;
  logic                    f1_flg, f1_dz;
  logic signed [DW+32:0]   f1_pre, f1_pim;
  logic [DIV_BITS-1:0]     qr, qi;
  logic [DW:0]             t_qr, t_qi, t_rt, t_an;
  logic signed [CW-1:0]    cc, ss;
  logic signed [32:0]      c33, s33;

  always_comb begin
    it   = stg[ITERS];
    qr   = it.big_re ? DIV_BITS'(1) << DW : it.q_re;
    qi   = it.big_im ? DIV_BITS'(1) << DW : it.q_im;
    t_qr = sat16(it.nneg_re && (qr != '0), 64'(qr));
    t_qi = sat16(it.nneg_im && (qi != '0), 64'(qi));
    t_rt = sat16(1'b0, 64'(it.sq_r));
    t_an = it.zero ? '0 : rnd_sat(64'(it.cz), 30 - FB);
    cc   = it.flip ? -it.cx : it.cx;
    ss   = it.flip ? -it.cy : it.cy;
    c33  = cc[32:0];
    s33  = ss[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else begin
      f1_vld <= it.vld;
    end
    f1_op  <= it.op;
    f1_dz  <= it.dz;
    f1_pre <= it.ar * c33;
    f1_pim <= it.ar * s33;
    unique case (it.op)
      OP_DIV: begin
        f1_rr  <= it.dz ? '0 : t_qr[DW-1:0];
        f1_ri  <= it.dz ? '0 : t_qi[DW-1:0];
        f1_flg <= !it.dz && (t_qr[DW] | t_qi[DW]);
      end
      OP_MAG: begin
        f1_rr  <= t_rt[DW-1:0];
        f1_ri  <= '0;
        f1_flg <= t_rt[DW];
      end
      OP_ARG: begin
        f1_rr  <= t_an[DW-1:0];
        f1_ri  <= '0;
        f1_flg <= t_an[DW];
      end
      OP_ADD, OP_SUB, OP_MUL, OP_MAGSQ, OP_POLAR: begin
        f1_rr  <= it.rr;
        f1_ri  <= it.ri;
        f1_flg <= it.flg;
      end
    endcase
  end

  // finish stage 2: polar rounding, status, output register
  logic [DW:0] t_pr, t_pi;
  op_t         res_op;
  logic        o_flg;

  always_comb begin
    t_pr  = rnd_sat(64'(f1_pre), 30);
    t_pi  = rnd_sat(64'(f1_pim), 30);
    o_flg = (f1_op == OP_POLAR) ? (t_pr[DW] | t_pi[DW]) : f1_flg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_vld;
    end
    res_op <= f1_op;
    if (f1_op == OP_POLAR) begin
      res.res_re <= t_pr[DW-1:0];
      res.res_im <= t_pi[DW-1:0];
    end else begin
      res.res_re <= f1_rr;
      res.res_im <= f1_ri;
    end
    if (f1_op == OP_DIV && f1_dz) begin
      res.status <= ST_DIV0;
    end else if (o_flg) begin
      res.status <= ST_SAT;
    end else begin
      res.status <= ST_OK;
    end
  end

`ifndef SYNTHESIS
  a_scalar_im: assert property (@(posedge clk) disable iff (rst)
    done && (res_op == OP_MAGSQ || res_op == OP_MAG || res_op == OP_ARG)
      |-> res.res_im == '0)
    else $error("scalar result with nonzero imaginary part");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.status == ST_DIV0 |-> res_op == OP_DIV && res.res_re == '0
      && res.res_im == '0)
    else $error("division-by-zero status on a bad transaction");

  a_done_flow: assert property (@(posedge clk) disable iff (rst)
    f1_vld |=> done)
    else $error("finished transaction dropped");
`endif

endmodule

// ===== hdl/cau_iter.sv =====
`timescale 1ns / 1ps
module cau_iter #(
  parameter int IDX = 0,
  parameter int CS  = cau_pkg::CORDIC_STEPS
) (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::iter_t d,
  output cau_pkg::iter_t q
);
  import cau_pkg::*;

  localparam int DJ = (IDX < DIV_BITS) ? DIV_BITS - 1 - IDX : 0;
  localparam int SB = (IDX < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
  localparam int CI = (IDX < CS) ? IDX : 0;

  iter_t                n;
  logic [REM_W-1:0]     dsh;
  logic [2*DW:0]        bsq;
  logic [2*DW:0]        sum;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic                 up;

  always_comb begin
    n   = d;
    dsh = REM_W'(d.den) << DJ;
    bsq = (2*DW+1)'(1) << SB;
    sum = {1'b0, d.sq_r} + bsq;
    xs  = d.cx >>> CI;
    ys  = d.cy >>> CI;
    at  = cau_atan(CI);
    up  = d.vec ? d.cy[CW-1] : !d.cz[ZW-1];
    if (IDX < DIV_BITS) begin
      if (d.rem_re >= dsh) begin
        n.rem_re   = d.rem_re - dsh;
        n.q_re[DJ] = 1'b1;
      end
      if (d.rem_im >= dsh) begin
        n.rem_im   = d.rem_im - dsh;
        n.q_im[DJ] = 1'b1;
      end
    end
    if (IDX < SQRT_STEPS) begin
      if ({1'b0, d.sq_n} >= sum) begin
        n.sq_n = d.sq_n - sum[2*DW-1:0];
        n.sq_r = (d.sq_r >> 1) + bsq[2*DW-1:0];
      end else begin
        n.sq_r = d.sq_r >> 1;
      end
    end
    if (IDX < CS) begin
      if (up) begin
        n.cx = d.cx - ys;
        n.cy = d.cy + xs;
        n.cz = d.cz - at;
      end else begin
        n.cx = d.cx + ys;
        n.cy = d.cy - xs;
        n.cz = d.cz + at;
      end
    end
    n.vld = d.vld && !rst;
  end

  always_ff @(posedge clk) begin
    q <= n;
  end

endmodule
